### hdl/tcw_pkg.sv
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [7:0] CHAR_NL    = 8'd10;
    localparam logic [7:0] CHAR_BS    = 8'd8;

    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_GOTO  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_ATTR = 1'b1;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_GOTO  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
        logic [7:0] col;
        logic [7:0] row;
    } t_in_item;

    typedef struct packed {
        logic       fwd_valid;
        logic [1:0] fwd_kind;
        logic [7:0] fwd_arg0;
        logic [7:0] fwd_arg1;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } t_out_item;

endpackage

### hdl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/text_console_writer_core.sv
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_ready    | i_in  (t_in_item)
// out     | output    | o_out_valid / i_out_ready  | o_out (t_out_item)
// config  | input     | psel, penable, pwrite      | paddr, pwdata, prdata
//
// Put without scroll, goto, clear in message mode and out-of-range read load the result directly.
// Read in range: the result waits for the registered read of the screen RAM.
// Scroll: one RAM write per cell of the new bottom row.
// Clear: one RAM write per cell.
// After reset a clearing pass over all ROWS*COLUMNS cells (2000) runs before any item.
// A new item is taken only while the result register is empty or being drained.
module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int DEPTH = COLUMNS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADDR_END = AW'(DEPTH - 1);

    t_state          r_state, n_state;
    logic            r_mode;
    logic [7:0]      r_attr;
    logic [CW-1:0]   r_cur_col, n_cur_col;
    logic [RW-1:0]   r_cur_row, n_cur_row;
    logic [RW-1:0]   r_top, n_top;
    logic [AW-1:0]   r_fill_addr;
    logic [AW-1:0]   r_fill_last;
    logic [15:0]     r_fill_cell;
    t_out_item       r_res, n_res;
    t_out_item       r_out;
    logic            r_out_valid;

    logic            accept;
    logic            cfg_write;
    logic            in_range;
    logic            put_write, put_down, put_scroll;
    logic [CW-1:0]   put_col;
    logic [RW-1:0]   put_row;
    logic            need_fill, need_read, cell_we;
    logic [AW-1:0]   fill_start, fill_last;
    logic [15:0]     fill_cell;
    logic [7:0]      col8, row8;
    logic            fill_end;
    logic            out_load;
    t_out_item       out_next;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [15:0]     mem_wdata, mem_rdata;

    function automatic logic [RW-1:0] phys_row(logic [RW-1:0] row, logic [RW-1:0] top);
        logic [RW:0] sum;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (RW+1)'(ROWS)) begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] row_base(logic [RW-1:0] prow);
        return AW'(AW'(prow) * AW'(COLUMNS));
    endfunction

    assign accept    = i_in_valid && o_in_ready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign in_range  = ({1'b0, i_in.col} < 9'(COLUMNS)) && ({1'b0, i_in.row} < 9'(ROWS));

    always_comb begin
        put_write  = 1'b0;
        put_down   = 1'b0;
        put_scroll = 1'b0;
        put_col    = r_cur_col;
        put_row    = r_cur_row;
        case (i_in.ch)
            CHAR_NL: begin
                put_col  = '0;
                put_down = 1'b1;
            end
            CHAR_BS: begin
                if (r_cur_col != '0) begin
                    put_col = r_cur_col - 1'b1;
                end else if (r_cur_row != '0) begin
                    put_col = COL_LAST;
                    put_row = r_cur_row - 1'b1;
                end
            end
            default: begin
                put_write = 1'b1;
                if (r_cur_col == COL_LAST) begin
                    put_col  = '0;
                    put_down = 1'b1;
                end else begin
                    put_col = r_cur_col + 1'b1;
                end
            end
        endcase
        if (put_down) begin
            if (r_cur_row == ROW_LAST) begin
                put_scroll = 1'b1;
            end else begin
                put_row = r_cur_row + 1'b1;
            end
        end
    end

    always_comb begin
        n_cur_col  = r_cur_col;
        n_cur_row  = r_cur_row;
        n_top      = r_top;
        need_fill  = 1'b0;
        need_read  = 1'b0;
        cell_we    = 1'b0;
        fill_start = '0;
        fill_last  = ADDR_END;
        fill_cell  = {r_attr, 8'h00};
        n_res      = '0;
        unique case (i_in.op)
            OP_PUT: begin
                if (r_mode) begin
                    n_res.fwd_valid = 1'b1;
                    n_res.fwd_kind  = KIND_PUT;
                    n_res.fwd_arg0  = i_in.ch;
                    n_res.fwd_arg1  = r_attr;
                end else begin
                    n_cur_col = put_col;
                    n_cur_row = put_row;
                    cell_we   = put_write;
                    if (put_scroll) begin
                        need_fill  = 1'b1;
                        n_top      = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                        fill_start = row_base(r_top);
                        fill_last  = row_base(r_top) + AW'(COLUMNS - 1);
                    end
                end
            end
            OP_GOTO: begin
                if (in_range) begin
                    n_cur_col = CW'(i_in.col);
                    n_cur_row = RW'(i_in.row);
                    if (r_mode) begin
                        n_res.fwd_valid = 1'b1;
                        n_res.fwd_kind  = KIND_GOTO;
                        n_res.fwd_arg0  = i_in.col;
                        n_res.fwd_arg1  = i_in.row;
                    end
                end
            end
            OP_CLEAR: begin
                if (r_mode) begin
                    n_res.fwd_valid = 1'b1;
                    n_res.fwd_kind  = KIND_CLEAR;
                    n_res.fwd_arg0  = r_attr;
                end else begin
                    n_cur_col = '0;
                    n_cur_row = '0;
                    n_top     = '0;
                    need_fill = 1'b1;
                end
            end
            OP_READ: begin
                need_read = in_range;
            end
        endcase
        col8 = 8'(n_cur_col);
        row8 = 8'(n_cur_row);
        n_res.cursor_col = col8[6:0];
        n_res.cursor_row = row8[4:0];
    end

    assign mem_raddr = row_base(phys_row(RW'(i_in.row), r_top)) + AW'(CW'(i_in.col));
    assign fill_end  = (r_fill_addr == r_fill_last);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (fill_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && need_read) begin
                    n_state = ST_READ;
                end else if (accept && need_fill) begin
                    n_state = ST_FILL;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            ST_FILL: begin
                if (fill_end) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_fill_addr;
        mem_wdata  = r_fill_cell;
        out_load   = 1'b0;
        out_next   = r_res;
        unique case (r_state)
            ST_INIT: begin
                mem_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
                mem_we     = accept && cell_we;
                mem_waddr  = row_base(phys_row(r_cur_row, r_top)) + AW'(r_cur_col);
                mem_wdata  = {r_attr, i_in.ch};
                out_load   = accept && !need_read && !need_fill;
                out_next   = n_res;
            end
            ST_READ: begin
                out_load           = 1'b1;
                out_next.cell_char = mem_rdata[7:0];
                out_next.cell_attr = mem_rdata[15:8];
            end
            ST_FILL: begin
                mem_we   = 1'b1;
                out_load = fill_end;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_mode      <= 1'b0;
            r_attr      <= RESET_ATTR;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_fill_addr <= '0;
            r_fill_last <= ADDR_END;
            r_fill_cell <= {RESET_ATTR, 8'h00};
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write) begin
                unique case (paddr[2])
                    REG_MODE: r_mode <= pwdata[0];
                    REG_ATTR: r_attr <= pwdata[7:0];
                endcase
            end
            if (accept) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                r_top     <= n_top;
                if (need_fill) begin
                    r_fill_addr <= fill_start;
                    r_fill_last <= fill_last;
                    r_fill_cell <= fill_cell;
                end
            end else if ((r_state == ST_INIT || r_state == ST_FILL) && !fill_end) begin
                r_fill_addr <= r_fill_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
        if (out_load) begin
            r_out <= out_next;
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_ATTR) ? {24'h0, r_attr} : {31'h0, r_mode};

endmodule

### test/text_console_writer_core_test.sv
module text_console_writer_core_test
    import tcw_pkg::*;
();

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 200;

    localparam logic [2:0] ADDR_MODE = {REG_MODE, 2'b00};
    localparam logic [2:0] ADDR_ATTR = {REG_ATTR, 2'b00};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    text_console_writer_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // screen cells as {attr, char}
    logic [15:0] screen_model [CELLS];
    int          cursor_col_model;
    int          cursor_row_model;
    logic        mode_forward_reg;
    logic [7:0]  color_attr_reg;

    t_out_item   pending_results [$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        long_hold = 1'b0;
    int          hold_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_out_item apply_console_op(t_in_item it);
        t_out_item r;
        r = '0;
        case (it.op)
            OP_PUT: begin
                if (mode_forward_reg) begin
                    r.fwd_valid = 1'b1;
                    r.fwd_kind  = KIND_PUT;
                    r.fwd_arg0  = it.ch;
                    r.fwd_arg1  = color_attr_reg;
                end else begin
                    if (it.ch == CHAR_NL) begin
                        cursor_col_model = 0;
                        cursor_row_model++;
                    end else if (it.ch == CHAR_BS) begin
                        if (cursor_col_model > 0) begin
                            cursor_col_model--;
                        end else if (cursor_row_model > 0) begin
                            cursor_col_model = COLUMNS - 1;
                            cursor_row_model--;
                        end
                    end else begin
                        screen_model[cursor_row_model * COLUMNS + cursor_col_model] =
                            {color_attr_reg, it.ch};
                        cursor_col_model++;
                    end
                    if (cursor_col_model >= COLUMNS) begin
                        cursor_col_model = 0;
                        cursor_row_model++;
                    end
                    if (cursor_row_model >= ROWS) begin
                        for (int i = 0; i < CELLS - COLUMNS; i++) begin
                            screen_model[i] = screen_model[i + COLUMNS];
                        end
                        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                            screen_model[i] = {color_attr_reg, 8'h00};
                        end
                        cursor_row_model = ROWS - 1;
                    end
                end
            end
            OP_GOTO: begin
                if (it.col < COLUMNS && it.row < ROWS) begin
                    cursor_col_model = int'(it.col);
                    cursor_row_model = int'(it.row);
                    if (mode_forward_reg) begin
                        r.fwd_valid = 1'b1;
                        r.fwd_kind  = KIND_GOTO;
                        r.fwd_arg0  = it.col;
                        r.fwd_arg1  = it.row;
                    end
                end
            end
            OP_CLEAR: begin
                if (mode_forward_reg) begin
                    r.fwd_valid = 1'b1;
                    r.fwd_kind  = KIND_CLEAR;
                    r.fwd_arg0  = color_attr_reg;
                end else begin
                    cursor_col_model = 0;
                    cursor_row_model = 0;
                    for (int i = 0; i < CELLS; i++) begin
                        screen_model[i] = {color_attr_reg, 8'h00};
                    end
                end
            end
            default: begin
                if (it.col < COLUMNS && it.row < ROWS) begin
                    {r.cell_attr, r.cell_char} = screen_model[it.row * COLUMNS + it.col];
                end
            end
        endcase
        r.cursor_col = cursor_col_model[6:0];
        r.cursor_row = cursor_row_model[4:0];
        return r;
    endfunction

    function automatic t_in_item make_item(t_op op, logic [7:0] ch, logic [7:0] col,
                                           logic [7:0] row);
        t_in_item it;
        it.op  = op;
        it.ch  = ch;
        it.col = col;
        it.row = row;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        it.ch  = 8'($urandom_range(0, 255));
        it.col = 8'($urandom_range(0, 255));
        it.row = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 999);
        if (pick < 690) begin
            it.op = OP_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                it.ch = CHAR_NL;
            end else if (pick < 17) begin
                it.ch = CHAR_BS;
            end
        end else if (pick < 840) begin
            it.op = OP_GOTO;
            if ($urandom_range(0, 9) != 0) begin
                it.col = 8'($urandom_range(0, COLUMNS - 1));
                it.row = 8'($urandom_range(0, 1) ? $urandom_range(ROWS - 5, ROWS - 1)
                                                 : $urandom_range(0, ROWS - 1));
            end
        end else if (pick < 990) begin
            it.op = OP_READ;
            if ($urandom_range(0, 9) != 0) begin
                it.col = 8'($urandom_range(0, COLUMNS - 1));
                it.row = 8'($urandom_range(0, ROWS - 1));
            end
        end else begin
            it.op = OP_CLEAR;
        end
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        pending_results.push_back(apply_console_op(it));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_MODE) begin
            mode_forward_reg = data[0];
        end else begin
            color_attr_reg = data[7:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        readback = (addr == ADDR_MODE) ? {31'b0, mode_forward_reg} : {24'b0, color_attr_reg};
        if (prdata !== readback) begin
            errors++;
            $display("%0t: register %0d readback: expected %h, actual %h",
                     $time, addr, readback, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        out_ready <= (long_hold && hold_count < HOLD_CYCLES) ? 1'b0
                   : ($urandom_range(0, 99) >= recv_idle_pct);
        if (!long_hold) begin
            hold_count <= 0;
        end else if (hold_count < HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected item: expected none, actual %h", $time, out_item);
            end else begin
                want = pending_results.pop_front();
                check_field("fwd_valid", 8'(want.fwd_valid), 8'(out_item.fwd_valid));
                check_field("fwd_kind", 8'(want.fwd_kind), 8'(out_item.fwd_kind));
                check_field("fwd_arg0", want.fwd_arg0, out_item.fwd_arg0);
                check_field("fwd_arg1", want.fwd_arg1, out_item.fwd_arg1);
                check_field("cursor_col", 8'(want.cursor_col), 8'(out_item.cursor_col));
                check_field("cursor_row", 8'(want.cursor_row), 8'(out_item.cursor_row));
                check_field("cell_char", want.cell_char, out_item.cell_char);
                check_field("cell_attr", want.cell_attr, out_item.cell_attr);
            end
        end
    end

    task automatic test_reset_state();
        send_item(make_item(OP_READ, 8'hFF, 8'd0, 8'd0));
        send_item(make_item(OP_READ, 8'h00, 8'd79, 8'd24));
        send_item(make_item(OP_READ, 8'h00, 8'd80, 8'd24));
        send_item(make_item(OP_READ, 8'h00, 8'd0, 8'd255));
        send_item(make_item(OP_PUT, 8'h41, 8'hFF, 8'hFF));
        send_item(make_item(OP_PUT, 8'hFF, 8'd0, 8'd0));
        send_item(make_item(OP_PUT, 8'h00, 8'd0, 8'd0));
        send_item(make_item(OP_PUT, CHAR_BS, 8'd0, 8'd0));
        send_item(make_item(OP_READ, 8'h00, 8'd1, 8'd0));
        send_item(make_item(OP_PUT, CHAR_NL, 8'd0, 8'd0));
        send_item(make_item(OP_PUT, CHAR_BS, 8'd0, 8'd0));
        send_item(make_item(OP_GOTO, 8'h00, 8'd0, 8'd0));
        send_item(make_item(OP_PUT, CHAR_BS, 8'd0, 8'd0));
        send_item(make_item(OP_GOTO, 8'h00, 8'd80, 8'd3));
        send_item(make_item(OP_GOTO, 8'h00, 8'd3, 8'd25));
        send_item(make_item(OP_GOTO, 8'h00, 8'd79, 8'd23));
        send_item(make_item(OP_PUT, 8'h5A, 8'd0, 8'd0));
        send_item(make_item(OP_GOTO, 8'h00, 8'd79, 8'd24));
        send_item(make_item(OP_PUT, 8'h7E, 8'd0, 8'd0));
        send_item(make_item(OP_PUT, CHAR_NL, 8'd0, 8'd0));
        send_item(make_item(OP_READ, 8'h00, 8'd79, 8'd21));
        send_item(make_item(OP_CLEAR, 8'h00, 8'd0, 8'd0));
        send_item(make_item(OP_READ, 8'h00, 8'd79, 8'd21));
        wait_idle();
    endtask

    task automatic test_message_mode();
        write_reg(ADDR_MODE, 32'd1);
        write_reg(ADDR_ATTR, 32'hA5);
        send_item(make_item(OP_PUT, 8'h42, 8'd5, 8'd5));
        send_item(make_item(OP_GOTO, 8'h00, 8'd40, 8'd12));
        send_item(make_item(OP_GOTO, 8'h00, 8'd80, 8'd12));
        send_item(make_item(OP_CLEAR, 8'h00, 8'd0, 8'd0));
        send_item(make_item(OP_READ, 8'h00, 8'd79, 8'd24));
        wait_idle();
    endtask

    task automatic test_random_traffic(int send_pct, int recv_pct, logic mode,
                                       logic [7:0] attr);
        wait_idle();
        write_reg(ADDR_MODE, {31'b0, mode});
        write_reg(ADDR_ATTR, {24'b0, attr});
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (PHASE_ITEMS) send_item(random_item());
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(ADDR_MODE, 32'd0);
        send_idle_pct = 0;
        long_hold <= 1'b1;
        repeat (30) send_item(random_item());
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (hold_count < HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            screen_model[i] = {RESET_ATTR, 8'h00};
        end
        cursor_col_model = 0;
        cursor_row_model = 0;
        mode_forward_reg = 1'b0;
        color_attr_reg   = RESET_ATTR;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_message_mode();
        test_random_traffic(17, 47, 1'b0, 8'h00);
        test_random_traffic(17, 47, 1'b0, 8'hFF);
        test_random_traffic(17, 47, 1'b1, 8'h3C);
        test_random_traffic(47, 17, 1'b0, 8'h1E);
        test_random_traffic(47, 17, 1'b1, 8'h00);
        test_random_traffic(47, 17, 1'b0, 8'h7F);
        test_random_traffic(0, 0, 1'b0, 8'hF0);
        test_random_traffic(0, 0, 1'b1, 8'hFF);
        test_random_traffic(0, 0, 1'b0, RESET_ATTR);
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
